[rtl/core/addressable_led_pulse_encoder_macros.svh]
// Assertion macros shared by the addressable LED pulse encoder RTL.
`ifndef ADDRESSABLE_LED_PULSE_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_PULSE_ENCODER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ALPE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ALPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/alpe_pkg.sv]
// Package with shared types and constants of the addressable LED pulse encoder.
package alpe_pkg;

  localparam int COLOUR_BITS_DEFAULT = 8;
  localparam int TIMER_WIDTH_DEFAULT = 16;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int SHORT_LEN_WIDTH = 10;
  localparam int GAP_LEN_WIDTH   = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP       = 3'd4;

  localparam logic [SHORT_LEN_WIDTH-1:0] ZERO_HIGH_RESET = 10'd26;
  localparam logic [SHORT_LEN_WIDTH-1:0] ZERO_LOW_RESET  = 10'd54;
  localparam logic [SHORT_LEN_WIDTH-1:0] ONE_HIGH_RESET  = 10'd51;
  localparam logic [SHORT_LEN_WIDTH-1:0] ONE_LOW_RESET   = 10'd29;
  localparam logic [GAP_LEN_WIDTH-1:0]   GAP_RESET       = 16'd3200;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_GAP  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_t;

endpackage

[rtl/core/addressable_led_pulse_encoder.sv]
// Top level of the addressable LED pulse encoder: holding register, bit timer and line output.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | into      | in_valid/in_stall  | mode, green, red, blue, last_pixel
//   out     | out of    | out_valid/out_stall| line_level, pixel_taken, busy_res
//   cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// One request is taken every cycle unless a result stalls; its result reaches the output register in the next cycle.
// The single result register sets the rate: a request enters whenever that register is empty
// or being emptied in the same cycle.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled result holds the output register and stalls the input side.
`include "addressable_led_pulse_encoder_macros.svh"

module addressable_led_pulse_encoder #(
  parameter int COLOUR_BITS = alpe_pkg::COLOUR_BITS_DEFAULT,
  parameter int TIMER_WIDTH = alpe_pkg::TIMER_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic [COLOUR_BITS-1:0]                green,
  input  logic [COLOUR_BITS-1:0]                red,
  input  logic [COLOUR_BITS-1:0]                blue,
  input  logic                                  last_pixel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  line_level,
  output logic                                  pixel_taken,
  output logic                                  busy_res,
  input  logic                                  cfg_we,
  input  logic [alpe_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [alpe_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  localparam int PB  = 3 * COLOUR_BITS;
  localparam int BLW = $clog2(PB + 1);
  localparam int TW  = TIMER_WIDTH;
  localparam logic [31:0] TMR_MAX = (32'd1 << TW) - 32'd1;

  typedef struct packed {
    alpe_pkg::phase_t phase;
    logic [TW-1:0]    timer;
    logic [PB-1:0]    shift;
    logic [BLW-1:0]   bits_left;
    logic             held_valid;
    logic             frame_open;
    logic             sending_last;
  } enc_state_t;

  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] zero_high_cycles;
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] zero_low_cycles;
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] one_high_cycles;
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] one_low_cycles;
  logic [alpe_pkg::GAP_LEN_WIDTH-1:0]   gap_cycles;

  enc_state_t    enc, enc_next;
  logic [PB-1:0] held_pixel, held_pixel_next;
  logic          held_last, held_last_next;
  logic          line_now, line_now_next;
  logic          taken_next, busy_next;
  logic          in_accept;

  logic [TW-1:0] zero_high_len, zero_low_len, one_high_len, one_low_len, gap_len;

  function automatic logic [TW-1:0] clamp_len(input logic [alpe_pkg::GAP_LEN_WIDTH-1:0] v);
    logic [TW-1:0] r;
    if (v == '0) begin
      r = TW'(1);
    end else if (32'(v) > TMR_MAX) begin
      r = '1;
    end else begin
      r = TW'(v);
    end
    return r;
  endfunction

  assign zero_high_len = clamp_len(alpe_pkg::GAP_LEN_WIDTH'(zero_high_cycles));
  assign zero_low_len  = clamp_len(alpe_pkg::GAP_LEN_WIDTH'(zero_low_cycles));
  assign one_high_len  = clamp_len(alpe_pkg::GAP_LEN_WIDTH'(one_high_cycles));
  assign one_low_len   = clamp_len(alpe_pkg::GAP_LEN_WIDTH'(one_low_cycles));
  assign gap_len       = clamp_len(gap_cycles);

  function automatic enc_state_t begin_bit(input enc_state_t s);
    enc_state_t r;
    r = s;
    r.phase = alpe_pkg::PH_HIGH;
    r.timer = s.shift[PB-1] ? one_high_len : zero_high_len;
    return r;
  endfunction

  function automatic enc_state_t load_next(input enc_state_t s, input logic [PB-1:0] px,
                                           input logic last);
    enc_state_t r;
    r = s;
    r.shift        = px;
    r.bits_left    = BLW'(PB);
    r.sending_last = last;
    r.held_valid   = 1'b0;
    if (!s.frame_open) begin
      r.phase = alpe_pkg::PH_GAP;
      r.timer = gap_len;
    end else begin
      r = begin_bit(r);
    end
    return r;
  endfunction

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    enc_state_t s;
    logic       active;
    s               = enc;
    held_pixel_next = held_pixel;
    held_last_next  = held_last;
    line_now_next   = line_now;
    taken_next      = 1'b0;
    busy_next       = 1'b0;
    if (mode == alpe_pkg::MODE_PIXEL) begin
      if (!s.held_valid) begin
        held_pixel_next = {green, red, blue};
        held_last_next  = last_pixel;
        s.held_valid    = 1'b1;
        taken_next      = 1'b1;
      end
      busy_next = s.held_valid | (s.phase != alpe_pkg::PH_IDLE);
    end else begin
      if (s.phase == alpe_pkg::PH_IDLE && s.held_valid) begin
        s = load_next(s, held_pixel, held_last);
      end
      active        = s.phase != alpe_pkg::PH_IDLE;
      line_now_next = s.phase == alpe_pkg::PH_HIGH;
      if (active) begin
        if (s.timer != '0) begin
          s.timer = s.timer - TW'(1);
        end
        if (s.timer == '0) begin
          case (s.phase)
            alpe_pkg::PH_GAP: begin
              s.frame_open = 1'b1;
              s = begin_bit(s);
            end
            alpe_pkg::PH_HIGH: begin
              s.phase = alpe_pkg::PH_LOW;
              s.timer = s.shift[PB-1] ? one_low_len : zero_low_len;
            end
            alpe_pkg::PH_LOW: begin
              if (s.bits_left != '0) begin
                s.bits_left = s.bits_left - BLW'(1);
              end
              s.shift = {s.shift[PB-2:0], 1'b0};
              if (s.bits_left != '0) begin
                s = begin_bit(s);
              end else begin
                if (s.sending_last) begin
                  s.frame_open = 1'b0;
                end
                s.sending_last = 1'b0;
                s.phase        = alpe_pkg::PH_IDLE;
                s.timer        = '0;
                if (s.held_valid) begin
                  s = load_next(s, held_pixel, held_last);
                end
              end
            end
            default: begin
              s = s;
            end
          endcase
        end
      end
      busy_next = active | s.held_valid;
    end
    enc_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_cycles <= alpe_pkg::ZERO_HIGH_RESET;
      zero_low_cycles  <= alpe_pkg::ZERO_LOW_RESET;
      one_high_cycles  <= alpe_pkg::ONE_HIGH_RESET;
      one_low_cycles   <= alpe_pkg::ONE_LOW_RESET;
      gap_cycles       <= alpe_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        alpe_pkg::REG_ZERO_HIGH: zero_high_cycles <= cfg_data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
        alpe_pkg::REG_ZERO_LOW:  zero_low_cycles  <= cfg_data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
        alpe_pkg::REG_ONE_HIGH:  one_high_cycles  <= cfg_data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
        alpe_pkg::REG_ONE_LOW:   one_low_cycles   <= cfg_data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
        alpe_pkg::REG_GAP:       gap_cycles       <= cfg_data[alpe_pkg::GAP_LEN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc.phase        <= alpe_pkg::PH_IDLE;
      enc.timer        <= '0;
      enc.shift        <= '0;
      enc.bits_left    <= '0;
      enc.held_valid   <= 1'b0;
      enc.frame_open   <= 1'b0;
      enc.sending_last <= 1'b0;
      held_last        <= 1'b0;
      line_now         <= 1'b0;
    end else if (in_accept) begin
      enc       <= enc_next;
      held_last <= held_last_next;
      line_now  <= line_now_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      held_pixel <= held_pixel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_level  <= line_now_next;
      pixel_taken <= taken_next;
      busy_res    <= busy_next;
    end
  end

  `ALPE_ASSERT_ALWAYS(a_idle_no_bits, (enc.phase != alpe_pkg::PH_IDLE) || (enc.bits_left == '0), "idle with bits left to send")
  `ALPE_ASSERT_ALWAYS(a_timer_live, (enc.phase == alpe_pkg::PH_IDLE) || (enc.timer != '0), "active phase with an expired timer")
  `ALPE_ASSERT_NEXT(a_tick_starts_held, in_accept && mode == alpe_pkg::MODE_TICK, !(enc.phase == alpe_pkg::PH_IDLE && enc.held_valid), "held pixel left waiting after a tick")
  `ALPE_ASSERT_ALWAYS(a_taken_busy, !(out_valid && pixel_taken) || busy_res, "stored pixel not reported as busy")

endmodule

[sim/tb_addressable_led_pulse_encoder.sv]
// Self-checking testbench for the addressable LED pulse encoder: request driver, result monitor.
module tb_addressable_led_pulse_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = alpe_pkg::COLOUR_BITS_DEFAULT;
  localparam int TW = alpe_pkg::TIMER_WIDTH_DEFAULT;
  localparam int PIX = 3 * CB;
  localparam logic [alpe_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [alpe_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic          mode;
    logic [CB-1:0] green;
    logic [CB-1:0] red;
    logic [CB-1:0] blue;
    logic          last_pixel;
  } request_t;

  typedef struct packed {
    logic line_level;
    logic pixel_taken;
    logic busy_res;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode;
  logic [CB-1:0] green, red, blue;
  logic last_pixel;
  logic out_valid;
  logic out_stall = 1'b0;
  logic line_level, pixel_taken, busy_res;
  logic cfg_we = 1'b0;
  logic [alpe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [alpe_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

  request_t offered = '0;
  request_t pending_q[$];
  reply_t expected_q[$];
  reply_t want;
  int error_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit long_hold_due = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  // Predictor state and its copy of the timing registers.
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] zero_hi = alpe_pkg::ZERO_HIGH_RESET;
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] zero_lo = alpe_pkg::ZERO_LOW_RESET;
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] one_hi = alpe_pkg::ONE_HIGH_RESET;
  logic [alpe_pkg::SHORT_LEN_WIDTH-1:0] one_lo = alpe_pkg::ONE_LOW_RESET;
  logic [alpe_pkg::GAP_LEN_WIDTH-1:0] gap_len = alpe_pkg::GAP_RESET;
  logic [PIX-1:0] held_pix = '0;
  logic [PIX-1:0] shifter = '0;
  bit held_ok = 1'b0;
  bit held_end = 1'b0;
  bit frame_on = 1'b0;
  bit last_in_flight = 1'b0;
  bit line_lvl = 1'b0;
  int unsigned bits_rem = 0;
  int unsigned ph_count = 0;
  alpe_pkg::phase_t ph = alpe_pkg::PH_IDLE;

  assign {mode, green, red, blue, last_pixel} = offered;

  addressable_led_pulse_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .green(green), .red(red), .blue(blue), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .line_level(line_level), .pixel_taken(pixel_taken), .busy_res(busy_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pulse_len(input int unsigned v);
    if (v == 0) v = 1;
    if (v > (2 ** TW) - 1) v = (2 ** TW) - 1;
    return v;
  endfunction

  function automatic void start_bit();
    ph = alpe_pkg::PH_HIGH;
    ph_count = pulse_len(32'(shifter[PIX-1] ? one_hi : zero_hi));
  endfunction

  function automatic void load_held();
    shifter = held_pix;
    bits_rem = PIX;
    last_in_flight = held_end;
    held_ok = 1'b0;
    if (!frame_on) begin
      ph = alpe_pkg::PH_GAP;
      ph_count = pulse_len(32'(gap_len));
    end else begin
      start_bit();
    end
  endfunction

  function automatic reply_t encode_request(input request_t r);
    reply_t y;
    bit active;
    y = '0;
    if (r.mode == alpe_pkg::MODE_PIXEL) begin
      if (!held_ok) begin
        held_pix = {r.green, r.red, r.blue};
        held_end = r.last_pixel;
        held_ok = 1'b1;
        y.pixel_taken = 1'b1;
      end
      y.busy_res = held_ok || ph != alpe_pkg::PH_IDLE;
    end else begin
      if (ph == alpe_pkg::PH_IDLE && held_ok) load_held();
      active = ph != alpe_pkg::PH_IDLE;
      line_lvl = ph == alpe_pkg::PH_HIGH;
      if (active) begin
        if (ph_count > 0) ph_count--;
        if (ph_count == 0) begin
          case (ph)
            alpe_pkg::PH_GAP: begin
              frame_on = 1'b1;
              start_bit();
            end
            alpe_pkg::PH_HIGH: begin
              ph = alpe_pkg::PH_LOW;
              ph_count = pulse_len(32'(shifter[PIX-1] ? one_lo : zero_lo));
            end
            alpe_pkg::PH_LOW: begin
              if (bits_rem > 0) bits_rem--;
              shifter = shifter << 1;
              if (bits_rem > 0) begin
                start_bit();
              end else begin
                if (last_in_flight) frame_on = 1'b0;
                last_in_flight = 1'b0;
                ph = alpe_pkg::PH_IDLE;
                ph_count = 0;
                if (held_ok) load_held();
              end
            end
            default: ;
          endcase
        end
      end
      y.busy_res = active || held_ok;
    end
    y.line_level = line_lvl;
    return y;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic got, input logic exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %b, predicted %b", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(encode_request(offered));
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          compare_field("line_level", line_level, want.line_level);
          compare_field("pixel_taken", pixel_taken, want.pixel_taken);
          compare_field("busy_res", busy_res, want.busy_res);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (long_hold_due && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < receiver_idle_pct;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [alpe_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [alpe_pkg::CFG_DATA_WIDTH-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      alpe_pkg::REG_ZERO_HIGH: zero_hi = data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
      alpe_pkg::REG_ZERO_LOW:  zero_lo = data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
      alpe_pkg::REG_ONE_HIGH:  one_hi = data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
      alpe_pkg::REG_ONE_LOW:   one_lo = data[alpe_pkg::SHORT_LEN_WIDTH-1:0];
      alpe_pkg::REG_GAP:       gap_len = data[alpe_pkg::GAP_LEN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [alpe_pkg::CFG_DATA_WIDTH-1:0] zh, zl, oh, ol, gap);
    write_reg(alpe_pkg::REG_ZERO_HIGH, zh);
    write_reg(alpe_pkg::REG_ZERO_LOW, zl);
    write_reg(alpe_pkg::REG_ONE_HIGH, oh);
    write_reg(alpe_pkg::REG_ONE_LOW, ol);
    write_reg(alpe_pkg::REG_GAP, gap);
  endtask

  task automatic push_pixel(input logic [CB-1:0] g, r, b, input logic last);
    pending_q.push_back('{alpe_pkg::MODE_PIXEL, g, r, b, last});
  endtask

  task automatic push_ticks(input int n);
    repeat (n) pending_q.push_back('{alpe_pkg::MODE_TICK, CB'($urandom), CB'($urandom),
                                     CB'($urandom), 1'($urandom)});
  endtask

  // Ticks until the line is idle and nothing is held.
  task automatic run_out();
    drain();
    while (ph != alpe_pkg::PH_IDLE || held_ok) begin
      push_ticks(8);
      drain();
    end
  endtask

  function automatic logic [alpe_pkg::CFG_DATA_WIDTH-1:0] rand_short();
    int unsigned len;
    len = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(3);
    return {6'($urandom), 10'(len)};
  endfunction

  initial begin
    #10_000_000;
    $display("FAIL addressable_led_pulse_encoder");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 8;
    receiver_idle_pct = 82;

    // Reset pulse lengths on a zero bit and a one bit, and a second pixel dropped.
    write_reg(alpe_pkg::REG_GAP, 16'd2);
    push_pixel(8'h7F, 8'h00, 8'hAA, 1'b1);
    push_pixel(8'h00, 8'hFF, 8'h55, 1'b0);
    push_ticks(170);
    drain();

    // Timing change while a pixel is partly sent.
    write_all(16'd3, 16'd2, 16'd4, 16'd1, 16'd2);
    run_out();

    // Zero lengths behave as one; spare indices are ignored.
    write_all(16'hFC00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    write_reg(REG_SPARE_FIRST, 16'h0005);
    write_reg(REG_SPARE_LAST, 16'hFFFF);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_ticks(1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    run_out();
    push_pixel(8'h5A, 8'hA5, 8'h3C, 1'b1);
    run_out();

    for (int round = 0; round < 12; round++) begin
      drain();
      if (round == 4) begin
        sender_idle_pct = 82;
        receiver_idle_pct = 8;
      end else if (round == 8) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      write_all(rand_short(), rand_short(), rand_short(), rand_short(),
                ($urandom_range(7) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(6)));
      if (round == 9) long_hold_due = 1'b1;
      for (int k = 0; k < 36; k++) begin
        if ($urandom_range(99) < 15)
          push_pixel(CB'($urandom), CB'($urandom), CB'($urandom), $urandom_range(3) == 0);
        else
          push_ticks(1);
      end
    end

    // Close the frame with the shortest pulses.
    drain();
    write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    push_pixel(CB'($urandom), CB'($urandom), CB'($urandom), 1'b1);
    run_out();

    drain();
    repeat (5) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("predicted results never arrived");
    if (error_count == 0) begin
      $display("PASS addressable_led_pulse_encoder");
    end else begin
      $display("FAIL addressable_led_pulse_encoder");
    end
    $finish;
  end

endmodule

[addressable_led_pulse_encoder.f]
+incdir+rtl/core
rtl/core/alpe_pkg.sv
rtl/core/addressable_led_pulse_encoder.sv
sim/tb_addressable_led_pulse_encoder.sv
